// ----- design/lcd4_pkg.sv -----
// Shared types and constants for the character-LCD 4-bit stream encoder.
// Holds operation codes, the queued command format and the instruction bytes.
// No dependencies.
`default_nettype none

package lcd4_pkg;

  typedef enum logic [2:0] {
    OP_PUT   = 3'd0,
    OP_CLEAR = 3'd1,
    OP_HOME  = 3'd2,
    OP_SET   = 3'd3,
    OP_INIT  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_INSTR = 2'd1,
    CMD_INIT  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] value;
  } cmd_t;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  localparam int unsigned STEP_W         = 4;
  localparam logic [3:0]  BYTE_LAST_STEP = 4'd3;
  localparam logic [3:0]  INIT_LAST_STEP = 4'd13;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] END_CHAR     = 8'h00;
  localparam logic [7:0] INSTR_CLEAR  = 8'h01;
  localparam logic [7:0] INSTR_HOME   = 8'h02;
  localparam logic [3:0] INIT_NIBBLE  = 4'h2;

  localparam int unsigned APB_AW         = 3;
  localparam logic        REG_BACKLIGHT  = 1'b0;

  localparam logic [6:0] ROW_START [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

  function automatic logic [7:0] init_byte(logic [1:0] i);
    logic [7:0] b;
    case (i)
      2'd0:    b = 8'h2C;
      2'd1:    b = 8'h0E;
      2'd2:    b = 8'h01;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ddram_addr(logic [1:0] row, logic [5:0] col);
    logic [6:0] sum;
    sum = ROW_START[row] + {1'b0, col};
    return {1'b1, sum};
  endfunction

endpackage

`default_nettype wire

// ----- design/lcd4_front.sv -----
// Front end: accepts LCD operations, tracks cursor and string state,
// and turns each operation into at most one queued command. Uses lcd4_pkg.
`default_nettype none

module lcd4_front #(
  parameter int unsigned COLUMNS          = 20,
  parameter int unsigned ROWS             = 4,
  parameter int unsigned MAX_STRING_CHARS = 80
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic              fifo_full_i,
  input  wire logic [2:0]        operation_i,
  input  wire logic [7:0]        character_i,
  input  wire logic              end_of_string_i,
  input  wire logic signed [5:0] move_columns_i,
  input  wire logic signed [3:0] move_rows_i,
  input  wire logic              relative_move_i,
  output logic                   cmd_valid_o,
  output lcd4_pkg::cmd_t         cmd_o
);

  localparam int unsigned CW  = $clog2(COLUMNS + 1);
  localparam int unsigned RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned NW  = $clog2(MAX_STRING_CHARS + 1);
  localparam int unsigned CUW = $clog2(16 * COLUMNS);
  localparam int unsigned RUW = $clog2(16 * ROWS) + 1;

  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [NW-1:0]  cnt_q, cnt_d;
  logic           drop_q, drop_d;
  logic [CUW-1:0] col_v;
  logic [RUW-1:0] row_v;
  logic [RW-1:0]  row_next;
  logic           accept;
  logic           at_end;

  assign accept   = push_i && !fifo_full_i;
  assign at_end   = (col_q >= CW'(COLUMNS));
  assign row_next = (row_q == RW'(ROWS - 1)) ? '0 : row_q + RW'(1);

  // modular wrap by conditional subtraction of 8x, 4x, 2x, 1x the modulus
  always_comb begin
    col_v = ((relative_move_i) ? CUW'(col_q) : '0) + CUW'(4 * COLUMNS)
            + {{(CUW-6){move_columns_i[5]}}, move_columns_i};
    for (int k = 3; k >= 0; k--) begin
      if (col_v >= CUW'(COLUMNS << k)) col_v = col_v - CUW'(COLUMNS << k);
    end
    row_v = ((relative_move_i) ? RUW'(row_q) : '0) + RUW'(8 * ROWS)
            + {{(RUW-4){move_rows_i[3]}}, move_rows_i};
    for (int k = 3; k >= 0; k--) begin
      if (row_v >= RUW'(ROWS << k)) row_v = row_v - RUW'(ROWS << k);
    end
  end

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind  = lcd4_pkg::CMD_INSTR;
    cmd_o.value = '0;
    if (accept) begin
      case (operation_i)
        lcd4_pkg::OP_PUT: begin
          if (character_i != lcd4_pkg::END_CHAR && !drop_q &&
              cnt_q < NW'(MAX_STRING_CHARS)) begin
            cnt_d       = cnt_q + NW'(1);
            cmd_valid_o = 1'b1;
            if (character_i == lcd4_pkg::NEWLINE_CHAR || at_end) begin
              row_d       = row_next;
              col_d       = '0;
              cmd_o.value = lcd4_pkg::ddram_addr(2'(row_next), 6'd0);
              if (at_end) drop_d = 1'b1;
            end else begin
              cmd_o.kind  = lcd4_pkg::CMD_DATA;
              cmd_o.value = character_i;
              col_d       = col_q + CW'(1);
            end
          end
          if (character_i == lcd4_pkg::END_CHAR || end_of_string_i) begin
            drop_d = 1'b0;
            cnt_d  = '0;
          end
        end
        lcd4_pkg::OP_CLEAR: begin
          row_d       = '0;
          col_d       = '0;
          cmd_valid_o = 1'b1;
          cmd_o.value = lcd4_pkg::INSTR_CLEAR;
        end
        lcd4_pkg::OP_HOME: begin
          row_d       = '0;
          col_d       = '0;
          cmd_valid_o = 1'b1;
          cmd_o.value = lcd4_pkg::INSTR_HOME;
        end
        lcd4_pkg::OP_SET: begin
          row_d       = RW'(row_v);
          col_d       = CW'(col_v);
          cmd_valid_o = 1'b1;
          cmd_o.value = lcd4_pkg::ddram_addr(2'(RW'(row_v)), 6'(CW'(col_v)));
        end
        lcd4_pkg::OP_INIT: begin
          row_d       = '0;
          col_d       = '0;
          cmd_valid_o = 1'b1;
          cmd_o.kind  = lcd4_pkg::CMD_INIT;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/lcd4_cmd_fifo.sv -----
// Short command queue between the front end and the nibble sequencer.
// Depth and command format come from lcd4_pkg.
`default_nettype none

module lcd4_cmd_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire lcd4_pkg::cmd_t  cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output lcd4_pkg::cmd_t       cmd_o,
  output logic                 empty_o
);

  lcd4_pkg::cmd_t                  mem_q [lcd4_pkg::FIFO_DEPTH];
  logic [lcd4_pkg::FIFO_PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [lcd4_pkg::FIFO_CW-1:0]    cnt_q, cnt_d;
  logic                            do_wr, do_rd;

  assign full_o  = (cnt_q == lcd4_pkg::FIFO_CW'(lcd4_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_wr ? wr_q + lcd4_pkg::FIFO_PW'(1) : wr_q;
    rd_d  = do_rd ? rd_q + lcd4_pkg::FIFO_PW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_wr && !do_rd) cnt_d = cnt_q + lcd4_pkg::FIFO_CW'(1);
    if (!do_wr && do_rd) cnt_d = cnt_q - lcd4_pkg::FIFO_CW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/lcd4_back.sv -----
// Back end: expands queued commands into expander bytes, one per cycle unless
// the receiver stalls, into an output register. Uses lcd4_pkg for command format and init bytes.
`default_nettype none

module lcd4_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  wire lcd4_pkg::cmd_t  cmd_i,
  output logic                 cmd_pop_o,
  input  wire logic            backlight_i,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output logic [7:0]           bus_byte_o,
  output logic                 last_o
);

  logic [lcd4_pkg::STEP_W-1:0] step_q, step_d, idx, last_step;
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  out_byte_q, byte_d;
  logic                        out_last_q;
  logic                        advance, cmd_done;
  logic [3:0]                  nib;
  logic                        en, rs;
  logic [7:0]                  ib;

  assign last_step = (cmd_i.kind == lcd4_pkg::CMD_INIT) ? lcd4_pkg::INIT_LAST_STEP
                                                       : lcd4_pkg::BYTE_LAST_STEP;
  assign advance   = cmd_valid_i && (!out_valid_q || pop_i);
  assign cmd_done  = (step_q == last_step);
  assign cmd_pop_o = advance && cmd_done;
  assign idx       = step_q - lcd4_pkg::STEP_W'(2);
  assign ib        = lcd4_pkg::init_byte(idx[3:2]);

  always_comb begin
    nib = cmd_i.value[7:4];
    en  = !step_q[0];
    rs  = 1'b0;
    case (cmd_i.kind)
      lcd4_pkg::CMD_INIT: begin
        if (step_q < lcd4_pkg::STEP_W'(2)) begin
          nib = lcd4_pkg::INIT_NIBBLE;
        end else begin
          nib = idx[1] ? ib[3:0] : ib[7:4];
          en  = !idx[0];
        end
      end
      lcd4_pkg::CMD_DATA: begin
        nib = step_q[1] ? cmd_i.value[3:0] : cmd_i.value[7:4];
        rs  = 1'b1;
      end
      default: begin
        nib = step_q[1] ? cmd_i.value[3:0] : cmd_i.value[7:4];
      end
    endcase
    byte_d = {nib, backlight_i, en, 1'b0, rs};
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      step_d      = cmd_done ? '0 : step_q + lcd4_pkg::STEP_W'(1);
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= byte_d;
      out_last_q <= cmd_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty_o    = !out_valid_q;
  assign bus_byte_o = out_byte_q;
  assign last_o     = out_last_q;

endmodule

`default_nettype wire

// ----- design/char_lcd_4bit_stream_encoder_unit.sv -----
// Top level of the character-LCD 4-bit stream encoder.
// Instantiates lcd4_front, lcd4_cmd_fifo and lcd4_back; uses lcd4_pkg.
//
// Usage: LCD operations enter through a queue-style port (push/full); a
// transaction completes on a clock edge with push high and full low.
// Expander bytes leave through a queue-style port (empty/pop); the byte on
// bus_byte_o is valid while empty is low and is taken when pop is high.
// last_o marks the final byte caused by one operation.
// A character, clear, home or set-cursor operation gives four bytes, init
// gives fourteen, and dropped characters or unused codes give none.
// With the queue idle, an accepted operation is written into the command
// queue and then its first byte into the output register.
// Throughput: one output byte per cycle from the nibble sequencer unless the
// receiver stalls; operations without output queue no command. A four-entry
// command queue decouples the two sides. When the receiver stalls, the output
// register holds its byte and the queue fills, then full rises. The backlight
// register (APB, byte address 0, bit 0) resets to on; reset empties the queue
// and zeroes the cursor.
`default_nettype none

module char_lcd_4bit_stream_encoder_unit #(
  parameter int unsigned COLUMNS          = 20,
  parameter int unsigned ROWS             = 4,
  parameter int unsigned MAX_STRING_CHARS = 80
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lcd4_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [2:0]                  operation_i,
  input  wire logic [7:0]                  character_i,
  input  wire logic                        end_of_string_i,
  input  wire logic signed [5:0]           move_columns_i,
  input  wire logic signed [3:0]           move_rows_i,
  input  wire logic                        relative_move_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [7:0]                       bus_byte_o,
  output logic                             last_o
);

  logic           backlight_q;
  logic           cfg_wr;
  logic           fe_valid;
  lcd4_pkg::cmd_t fe_cmd, q_cmd;
  logic           q_full, q_empty, q_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == lcd4_pkg::REG_BACKLIGHT);
  assign prdata = (paddr[2] == lcd4_pkg::REG_BACKLIGHT) ? {31'd0, backlight_q} : 32'd0;
  assign full   = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backlight_q <= 1'b1;
    end else if (cfg_wr) begin
      backlight_q <= pwdata[0];
    end
  end

  lcd4_front #(
    .COLUMNS          (COLUMNS),
    .ROWS             (ROWS),
    .MAX_STRING_CHARS (MAX_STRING_CHARS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .fifo_full_i     (q_full),
    .operation_i     (operation_i),
    .character_i     (character_i),
    .end_of_string_i (end_of_string_i),
    .move_columns_i  (move_columns_i),
    .move_rows_i     (move_rows_i),
    .relative_move_i (relative_move_i),
    .cmd_valid_o     (fe_valid),
    .cmd_o           (fe_cmd)
  );

  lcd4_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .cmd_i   (fe_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd),
    .empty_o (q_empty)
  );

  lcd4_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .backlight_i (backlight_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .bus_byte_o  (bus_byte_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// ----- design/lcd4_checker.sv -----
// Port-level checker for the character-LCD 4-bit stream encoder, bound
// to char_lcd_4bit_stream_encoder_unit. No package dependencies.
`default_nettype none

module lcd4_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] bus_byte_o,
  input wire logic       last_o
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result queue not empty during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(bus_byte_o) && $stable(last_o))
    else $error("stalled result changed");

  a_enable_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && bus_byte_o[2] |=>
      !empty && !bus_byte_o[2] &&
      (bus_byte_o[7:4] == $past(bus_byte_o[7:4])) &&
      (bus_byte_o[0] == $past(bus_byte_o[0])))
    else $error("enable-high nibble not followed by its enable-low copy");

  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && last_o |-> !bus_byte_o[2] && !bus_byte_o[1])
    else $error("final transaction byte has enable or read bit set");

endmodule

bind char_lcd_4bit_stream_encoder_unit lcd4_checker u_lcd4_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .bus_byte_o (bus_byte_o),
  .last_o     (last_o)
);

`default_nettype wire

// ----- test/char_lcd_4bit_stream_encoder_unit_tb.sv -----
// Self-checking testbench for char_lcd_4bit_stream_encoder_unit.
// Drives LCD operations through the push/full port, scores expander bytes against
// fixed byte lists or a cycle-free encoder model; uses lcd4_pkg and the design sources only.
`default_nettype none

module char_lcd_4bit_stream_encoder_unit_tb;

  localparam int CLK_PERIOD       = 8;
  localparam int COLUMNS          = 20;
  localparam int ROWS             = 4;
  localparam int MAX_STRING_CHARS = 80;
  localparam int PRED             = -1;

  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
  localparam logic [7:0] BIT_BL     = 8'h08;
  localparam logic [7:0] BIT_EN     = 8'h04;
  localparam logic [7:0] RS_DATA    = 8'h01;
  localparam logic [7:0] RS_INSTR   = 8'h00;
  localparam logic [7:0] FUNC_SET   = 8'h2C;
  localparam logic [7:0] DISPLAY_ON = 8'h0E;
  localparam logic [7:0] SET_ADDR   = 8'h80;
  localparam int LINE_BASE [4] = '{'h00, 'h40, 'h14, 'h54};
  localparam logic [lcd4_pkg::APB_AW-1:0] BL_ADDR =
    lcd4_pkg::APB_AW'(4 * int'(lcd4_pkg::REG_BACKLIGHT));

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
    logic       eos;
    logic [5:0] dx;
    logic [3:0] dy;
    logic       rel;
  } op_item_t;

  localparam int ITEM_W = $bits(op_item_t);

  typedef struct packed {
    op_item_t     it;
    int           known_n;
    logic [111:0] known;
  } plan_row_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } lcd_byte_t;

  localparam int PLAN_LEN = 21;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{'{lcd4_pkg::OP_PUT, 8'h41, 1'b0, 6'h00, 4'h0, 1'b0}, 4,
      {8'h4D, 8'h49, 8'h1D, 8'h19, 80'h0}},
    '{'{lcd4_pkg::OP_PUT, 8'hFF, 1'b0, 6'h00, 4'h0, 1'b0}, 4,
      {8'hFD, 8'hF9, 8'hFD, 8'hF9, 80'h0}},
    '{'{lcd4_pkg::OP_PUT, 8'h01, 1'b1, 6'h3F, 4'hF, 1'b1}, PRED, 112'h0},
    '{'{lcd4_pkg::OP_PUT, lcd4_pkg::END_CHAR, 1'b0, 6'h00, 4'h0, 1'b0}, 0, 112'h0},
    '{'{lcd4_pkg::OP_PUT, lcd4_pkg::NEWLINE_CHAR, 1'b0, 6'h00, 4'h0, 1'b0}, 4,
      {8'hCC, 8'hC8, 8'h0C, 8'h08, 80'h0}},
    '{'{lcd4_pkg::OP_SET, 8'h00, 1'b0, 6'h13, 4'h3, 1'b0}, 4,
      {8'hEC, 8'hE8, 8'h7C, 8'h78, 80'h0}},
    '{'{lcd4_pkg::OP_PUT, 8'h42, 1'b0, 6'h00, 4'h0, 1'b0}, PRED, 112'h0},
    '{'{lcd4_pkg::OP_PUT, 8'h43, 1'b0, 6'h00, 4'h0, 1'b0}, 4,
      {8'h8C, 8'h88, 8'h0C, 8'h08, 80'h0}},
    '{'{lcd4_pkg::OP_PUT, 8'h44, 1'b0, 6'h00, 4'h0, 1'b0}, 0, 112'h0},
    '{'{lcd4_pkg::OP_PUT, 8'h45, 1'b1, 6'h00, 4'h0, 1'b0}, 0, 112'h0},
    '{'{lcd4_pkg::OP_SET, 8'hFF, 1'b1, 6'h20, 4'h8, 1'b0}, PRED, 112'h0},
    '{'{lcd4_pkg::OP_SET, 8'h00, 1'b0, 6'h1F, 4'h7, 1'b1}, PRED, 112'h0},
    '{'{lcd4_pkg::OP_SET, 8'h00, 1'b0, 6'h3F, 4'hF, 1'b1}, PRED, 112'h0},
    '{'{lcd4_pkg::OP_SET, 8'h00, 1'b0, 6'h00, 4'h0, 1'b0}, 4,
      {8'h8C, 8'h88, 8'h0C, 8'h08, 80'h0}},
    '{'{lcd4_pkg::OP_CLEAR, 8'h00, 1'b0, 6'h00, 4'h0, 1'b0}, 4,
      {8'h0C, 8'h08, 8'h1C, 8'h18, 80'h0}},
    '{'{lcd4_pkg::OP_HOME, 8'h00, 1'b0, 6'h00, 4'h0, 1'b0}, 4,
      {8'h0C, 8'h08, 8'h2C, 8'h28, 80'h0}},
    '{'{lcd4_pkg::OP_INIT, 8'h00, 1'b0, 6'h00, 4'h0, 1'b0}, 14,
      {8'h2C, 8'h28, 8'h2C, 8'h28, 8'hCC, 8'hC8, 8'h0C, 8'h08,
       8'hEC, 8'hE8, 8'h0C, 8'h08, 8'h1C, 8'h18}},
    '{'{OP_UNUSED_FIRST, 8'h41, 1'b1, 6'h15, 4'h5, 1'b1}, 0, 112'h0},
    '{'{OP_UNUSED_LAST, 8'h00, 1'b0, 6'h2A, 4'hA, 1'b0}, 0, 112'h0},
    '{'{lcd4_pkg::OP_PUT, 8'h80, 1'b1, 6'h00, 4'h0, 1'b0}, PRED, 112'h0},
    '{'{lcd4_pkg::OP_PUT, 8'h7F, 1'b1, 6'h3F, 4'hF, 1'b1}, PRED, 112'h0}
  };

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b1;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [lcd4_pkg::APB_AW-1:0] paddr = '0;
  logic [31:0]       pwdata  = '0;
  logic              push    = 1'b0;
  logic [2:0]        operation     = '0;
  logic [7:0]        character     = '0;
  logic              end_of_string = 1'b0;
  logic [5:0]        move_columns  = '0;
  logic [3:0]        move_rows     = '0;
  logic              relative_move = 1'b0;
  logic              pop     = 1'b0;

  logic [31:0] prdata;
  logic        pready;
  logic        full;
  logic        empty;
  logic [7:0]  bus_byte_o;
  logic        last_o;

  // Encoder model state
  logic backlight  = 1'b1;
  int   cur_col    = 0;
  int   cur_row    = 0;
  int   str_count  = 0;
  logic dropping   = 1'b0;

  logic [7:0] op_bytes [$];
  lcd_byte_t  bytes_due [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int fault_count   = 0;

  char_lcd_4bit_stream_encoder_unit #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS),
    .MAX_STRING_CHARS(MAX_STRING_CHARS)
  ) DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .push(push),
    .full(full),
    .operation_i(operation),
    .character_i(character),
    .end_of_string_i(end_of_string),
    .move_columns_i(move_columns),
    .move_rows_i(move_rows),
    .relative_move_i(relative_move),
    .empty(empty),
    .pop(pop),
    .bus_byte_o(bus_byte_o),
    .last_o(last_o)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int wrap(int v, int m);
    int r;
    r = v % m;
    if (r < 0) r += m;
    return r;
  endfunction

  function automatic op_item_t noise_item();
    return op_item_t'(ITEM_W'($urandom));
  endfunction

  function automatic void emit_pair(logic [7:0] raw);
    logic [7:0] b;
    b = backlight ? (raw | BIT_BL) : (raw & ~BIT_BL);
    op_bytes.push_back(b | BIT_EN);
    op_bytes.push_back(b & ~BIT_EN);
  endfunction

  function automatic void emit_byte(logic [7:0] v, logic [7:0] rs);
    emit_pair((v & 8'hF0) | rs);
    emit_pair({v[3:0], 4'h0} | rs);
  endfunction

  function automatic void emit_address();
    emit_byte(SET_ADDR | 8'((LINE_BASE[cur_row] + cur_col) & 'h7F), RS_INSTR);
  endfunction

  task automatic encode_op(input op_item_t it);
    logic stop;
    op_bytes.delete();
    case (it.op)
      lcd4_pkg::OP_PUT: begin
        if (it.ch != lcd4_pkg::END_CHAR && !dropping && str_count < MAX_STRING_CHARS) begin
          stop = (cur_col >= COLUMNS);
          str_count++;
          if (it.ch == lcd4_pkg::NEWLINE_CHAR || stop) begin
            cur_row = (cur_row + 1) % ROWS;
            cur_col = 0;
            emit_address();
            if (stop) dropping = 1'b1;
          end else begin
            emit_byte(it.ch, RS_DATA);
            cur_col++;
          end
        end
        if (it.ch == lcd4_pkg::END_CHAR || it.eos) begin
          dropping  = 1'b0;
          str_count = 0;
        end
      end
      lcd4_pkg::OP_CLEAR, lcd4_pkg::OP_HOME: begin
        cur_row = 0;
        cur_col = 0;
        emit_byte((it.op == lcd4_pkg::OP_CLEAR) ? lcd4_pkg::INSTR_CLEAR
                                                : lcd4_pkg::INSTR_HOME, RS_INSTR);
      end
      lcd4_pkg::OP_SET: begin
        if (it.rel) begin
          cur_row = wrap(cur_row + int'($signed(it.dy)), ROWS);
          cur_col = wrap(cur_col + int'($signed(it.dx)), COLUMNS);
        end else begin
          cur_row = wrap(int'($signed(it.dy)), ROWS);
          cur_col = wrap(int'($signed(it.dx)), COLUMNS);
        end
        emit_address();
      end
      lcd4_pkg::OP_INIT: begin
        emit_pair({lcd4_pkg::INIT_NIBBLE, 4'h0});
        emit_byte(FUNC_SET, RS_INSTR);
        emit_byte(DISPLAY_ON, RS_INSTR);
        emit_byte(lcd4_pkg::INSTR_CLEAR, RS_INSTR);
        cur_row = 0;
        cur_col = 0;
      end
      default: ;
    endcase
  endtask

  // One transaction on the input port, then an optional sender gap.
  task automatic send_op(input op_item_t it, input int known_n, input logic [111:0] known);
    lcd_byte_t e;
    int n;
    operation     <= it.op;
    character     <= it.ch;
    end_of_string <= it.eos;
    move_columns  <= it.dx;
    move_rows     <= it.dy;
    relative_move <= it.rel;
    push          <= 1'b1;
    do @(posedge clk); while (full);
    encode_op(it);
    n = (known_n == PRED) ? op_bytes.size() : known_n;
    for (int k = 0; k < n; k++) begin
      e.b    = (known_n == PRED) ? op_bytes[k] : known[111 - 8*k -: 8];
      e.last = (k == n - 1);
      bytes_due.push_back(e);
    end
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic write_backlight(input logic on);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BL_ADDR;
    pwdata  <= {31'b0, on};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    backlight = on;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) pop <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : check_out
    lcd_byte_t want;
    if (rst_n && pop && !empty) begin
      if (bytes_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected byte %h last %b", bus_byte_o, last_o);
      end else begin
        want = bytes_due.pop_front();
        if (bus_byte_o !== want.b || last_o !== want.last) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                     want.b, want.last, bus_byte_o, last_o);
        end
      end
    end
  end

  initial begin
    int phase;
    int made;
    int target;
    int pick;
    int len;
    op_item_t it;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_backlight(1'b1);
    for (int r = 0; r < PLAN_LEN; r++) send_op(PLAN[r].it, PLAN[r].known_n, PLAN[r].known);

    for (phase = 0; phase < 4; phase++) begin
      drain();
      write_backlight(phase % 2 == 1);
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 70; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      made   = 0;
      target = (phase == 0) ? 92 : 25;

      if (phase == 0) begin
        // four lines of 19 characters and a newline fill the per-string cap; the tail is dropped
        it = noise_item();
        it.op = lcd4_pkg::OP_HOME;
        send_op(it, PRED, '0);
        for (int line = 0; line < 4; line++) begin
          for (int k = 0; k < 20; k++) begin
            it = noise_item();
            it.op  = lcd4_pkg::OP_PUT;
            it.eos = 1'b0;
            it.ch  = (k == 19) ? lcd4_pkg::NEWLINE_CHAR : 8'($urandom_range(255, 11));
            send_op(it, PRED, '0);
          end
        end
        for (int k = 0; k < 3; k++) begin
          it = noise_item();
          it.op  = lcd4_pkg::OP_PUT;
          it.ch  = 8'($urandom_range(255, 11));
          it.eos = (k == 2);
          send_op(it, PRED, '0);
        end
        made = 84;
      end

      while (made < target) begin
        pick = $urandom_range(99);
        it = noise_item();
        if (pick < 55) begin
          len = $urandom_range(26, 1);
          for (int k = 0; k < len; k++) begin
            it = noise_item();
            it.op  = lcd4_pkg::OP_PUT;
            it.ch  = ($urandom_range(9) == 0) ? lcd4_pkg::NEWLINE_CHAR
                                              : 8'($urandom_range(255, 1));
            it.eos = (k == len - 1) ? 1'($urandom) : 1'b0;
            send_op(it, PRED, '0);
            made++;
          end
          if (!it.eos) begin
            it = noise_item();
            it.op = lcd4_pkg::OP_PUT;
            it.ch = lcd4_pkg::END_CHAR;
            send_op(it, PRED, '0);
            made++;
          end
        end else if (pick < 70) begin
          it.op = lcd4_pkg::OP_SET;
          send_op(it, PRED, '0);
          made++;
        end else if (pick < 78) begin
          it.op = $urandom_range(1) ? lcd4_pkg::OP_CLEAR : lcd4_pkg::OP_HOME;
          send_op(it, PRED, '0);
          made++;
        end else if (pick < 83) begin
          it.op = lcd4_pkg::OP_INIT;
          send_op(it, PRED, '0);
          made++;
        end else if (pick < 90) begin
          it.op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
          send_op(it, PRED, '0);
        end else begin
          it.op = lcd4_pkg::OP_PUT;
          send_op(it, PRED, '0);
          made++;
        end
      end
    end

    drain();
    if (fault_count == 0 && bytes_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 400000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
